FILE: rtl/intt_pkg.sv
// Shared types, constants and helpers for the negacyclic inverse NTT block.
package intt_pkg;

   localparam int COEFF_WIDTH  = 30;
   localparam int MAX_LOG_SIZE = 12;
   localparam int ADDR_W       = MAX_LOG_SIZE;
   localparam int BF_W         = ADDR_W - 1;
   localparam int LOG_W        = 4;
   localparam int CSR_IDX_W    = 3;

   typedef logic [COEFF_WIDTH-1:0] coeff_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [LOG_W-1:0]       log_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_RUN   = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   localparam csr_idx_type CSR_MODULUS        = 3'd0;
   localparam csr_idx_type CSR_LOG_SIZE       = 3'd1;
   localparam csr_idx_type CSR_INVERSE_ROOT   = 3'd2;
   localparam csr_idx_type CSR_INVERSE_LENGTH = 3'd3;
   localparam csr_idx_type CSR_LAST_SCALE     = 3'd4;

   localparam coeff_type RST_MODULUS        = 30'd1053818881;
   localparam log_type   RST_LOG_SIZE       = 4'd12;
   localparam coeff_type RST_INVERSE_ROOT   = 30'd18959119;
   localparam coeff_type RST_INVERSE_LENGTH = 30'd1053561601;
   localparam coeff_type RST_LAST_SCALE     = 30'd543463427;

   typedef struct packed {
      func_type  func;
      addr_type  index;
      coeff_type value;
   } req_type;

   typedef struct packed {
      coeff_type read_value;
      logic      rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      ASEL_ONE,
      ASEL_POWER,
      ASEL_SUM,
      ASEL_DIFF
   } a_sel_type;

   typedef enum logic [2:0] {
      BSEL_INV_ROOT,
      BSEL_ROOT,
      BSEL_RDATA,
      BSEL_INV_LEN,
      BSEL_LAST,
      BSEL_TWIDDLE
   } b_sel_type;

   typedef enum logic [1:0] {
      WSEL_REQ,
      WSEL_SUM,
      WSEL_MUL
   } wsel_type;

   typedef struct packed {
      logic      coef_we;
      logic      coef_re;
      addr_type  coef_addr;
      wsel_type  coef_wsel;
      logic      tw_we;
      logic      tw_re;
      addr_type  tw_addr;
      logic      mul_start;
      a_sel_type mul_asel;
      b_sel_type mul_bsel;
      logic      ld_root;
      logic      ld_power;
      logic      ld_u;
      logic      ld_v;
      logic      ld_from_mul;
   } cmd_type;

   typedef struct packed {
      logic    mul_busy;
      logic    mul_done;
      logic    rdata_ge_q;
      logic    value_ge_q;
      log_type lg;
   } status_type;

   function automatic addr_type bitrev(input addr_type x);
      addr_type r;
      for (int i = 0; i < ADDR_W; i++) begin
         r[i] = x[ADDR_W-1-i];
      end
      return r;
   endfunction

endpackage

FILE: rtl/intt_modmul.sv
// Bit-serial modular multiplier: a*b mod q by double-and-add, a must be below q.
module intt_modmul
   import intt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  coeff_type a,
   input  coeff_type b,
   input  coeff_type q,
   output logic      busy,
   output logic      done,
   output coeff_type result
);

   localparam int CNT_W = $clog2(COEFF_WIDTH);

   coeff_type          acc_ff, a_ff, b_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [COEFF_WIDTH:0] dbl, dbl_red, add, add_red;

   always_comb begin
      dbl     = {1'b0, acc_ff} + {1'b0, acc_ff};
      dbl_red = (dbl >= {1'b0, q}) ? dbl - {1'b0, q} : dbl;
      add     = dbl_red + {1'b0, (b_ff[COEFF_WIDTH-1] ? a_ff : '0)};
      add_red = (add >= {1'b0, q}) ? add - {1'b0, q} : add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start && !busy_ff) begin
         acc_ff <= '0;
         a_ff   <= a;
         b_ff   <= b;
         cnt_ff <= CNT_W'(COEFF_WIDTH - 1);
      end else if (busy_ff) begin
         acc_ff <= add_red[COEFF_WIDTH-1:0];
         b_ff   <= {b_ff[COEFF_WIDTH-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff;

endmodule

FILE: rtl/intt_datapath.sv
// Datapath: registers, coefficient and twiddle memories, butterfly adders, multiplier.
module intt_datapath
   import intt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  csr_idx_type csr_index,
   input  coeff_type   csr_data,
   input  req_type     req,
   input  cmd_type     cmd,
   output status_type  status,
   output coeff_type   coef_rdata
);

   coeff_type modulus_ff, inv_root_ff, inv_len_ff, last_ff;
   log_type   log_size_ff;
   coeff_type q_eff;
   log_type   lg;

   coeff_type coef_mem [1<<ADDR_W];
   coeff_type tw_mem   [1<<ADDR_W];
   coeff_type coef_rdata_ff, tw_rdata_ff;
   coeff_type root_ff, power_ff, u_ff, v_ff;
   coeff_type sum, diff, coef_wdata, mul_a, mul_b, mul_res;
   logic      mul_busy, mul_done;
   logic [COEFF_WIDTH:0] sum_w, diff_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= RST_MODULUS;
         log_size_ff <= RST_LOG_SIZE;
         inv_root_ff <= RST_INVERSE_ROOT;
         inv_len_ff  <= RST_INVERSE_LENGTH;
         last_ff     <= RST_LAST_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:        modulus_ff  <= csr_data;
            CSR_LOG_SIZE:       log_size_ff <= csr_data[LOG_W-1:0];
            CSR_INVERSE_ROOT:   inv_root_ff <= csr_data;
            CSR_INVERSE_LENGTH: inv_len_ff  <= csr_data;
            CSR_LAST_SCALE:     last_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      q_eff = (modulus_ff < COEFF_WIDTH'(3)) ? COEFF_WIDTH'(3) : modulus_ff;
      if (log_size_ff < LOG_W'(2)) begin
         lg = LOG_W'(2);
      end else if (log_size_ff > LOG_W'(MAX_LOG_SIZE)) begin
         lg = LOG_W'(MAX_LOG_SIZE);
      end else begin
         lg = log_size_ff;
      end
      sum_w = {1'b0, u_ff} + {1'b0, v_ff};
      sum   = (sum_w >= {1'b0, q_eff}) ? sum_w[COEFF_WIDTH-1:0] - q_eff
                                       : sum_w[COEFF_WIDTH-1:0];
      diff_w = {1'b0, u_ff} - {1'b0, v_ff};
      diff   = (u_ff >= v_ff) ? diff_w[COEFF_WIDTH-1:0]
                              : diff_w[COEFF_WIDTH-1:0] + q_eff;
      case (cmd.mul_asel)
         ASEL_ONE:   mul_a = COEFF_WIDTH'(1);
         ASEL_POWER: mul_a = power_ff;
         ASEL_SUM:   mul_a = sum;
         default:    mul_a = diff;
      endcase
      case (cmd.mul_bsel)
         BSEL_INV_ROOT: mul_b = inv_root_ff;
         BSEL_ROOT:     mul_b = root_ff;
         BSEL_RDATA:    mul_b = coef_rdata_ff;
         BSEL_INV_LEN:  mul_b = inv_len_ff;
         BSEL_LAST:     mul_b = last_ff;
         default:       mul_b = tw_rdata_ff;
      endcase
      case (cmd.coef_wsel)
         WSEL_REQ: coef_wdata = req.value;
         WSEL_SUM: coef_wdata = sum;
         default:  coef_wdata = mul_res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_we) begin
         coef_mem[cmd.coef_addr] <= coef_wdata;
      end
      if (cmd.coef_re) begin
         coef_rdata_ff <= coef_mem[cmd.coef_addr];
      end
      if (cmd.tw_we) begin
         tw_mem[cmd.tw_addr] <= power_ff;
      end
      if (cmd.tw_re) begin
         tw_rdata_ff <= tw_mem[cmd.tw_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_root) begin
         root_ff  <= mul_res;
         power_ff <= mul_res;
      end else if (cmd.ld_power) begin
         power_ff <= mul_res;
      end
      if (cmd.ld_u) begin
         u_ff <= cmd.ld_from_mul ? mul_res : coef_rdata_ff;
      end
      if (cmd.ld_v) begin
         v_ff <= cmd.ld_from_mul ? mul_res : coef_rdata_ff;
      end
   end

   intt_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .q      (q_eff),
      .busy   (mul_busy),
      .done   (mul_done),
      .result (mul_res)
   );

   assign status.mul_busy   = mul_busy;
   assign status.mul_done   = mul_done;
   assign status.rdata_ge_q = coef_rdata_ff >= q_eff;
   assign status.value_ge_q = req.value >= q_eff;
   assign status.lg         = lg;
   assign coef_rdata        = coef_rdata_ff;

endmodule

FILE: rtl/intt_ctrl.sv
// Controller: item decode, twiddle build and butterfly sequencing.
module intt_ctrl
   import intt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  req_type    req,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid,
   output logic       rsp_rejected,
   output logic       rsp_read
);

   typedef enum logic [3:0] {
      S_IDLE, S_ROOT, S_ROOT_WAIT, S_TW_WRITE, S_TW_WAIT,
      S_RD_U, S_CHK_U, S_RED_U, S_RD_V, S_CHK_V, S_RED_V,
      S_BF_A, S_MUL_A, S_MUL_B
   } state_type;

   state_type        state_ff, state_in;
   addr_type         tw_cnt_ff, tw_cnt_in, slot_ff, slot_in;
   log_type          round_ff, round_in;
   logic [BF_W-1:0]  bf_ff, bf_in, mask, half_m1;
   logic             rsp_valid_ff, rsp_valid_in, rsp_rej_ff, rsp_rej_in;
   logic             rsp_rd_ff, rsp_rd_in;
   addr_type         n_m2, tt, k_lo, k_hi, tw_waddr;
   logic             last_round, accept;

   always_comb begin
      n_m2     = ADDR_W'((ADDR_W+1)'(1) << status.lg) - ADDR_W'(2);
      half_m1  = BF_W'(((ADDR_W+1)'(1) << (status.lg - LOG_W'(1))) - (ADDR_W+1)'(1));
      mask     = (BF_W'(1) << round_ff) - BF_W'(1);
      tt       = ADDR_W'(1) << round_ff;
      k_lo     = {bf_ff & ~mask, 1'b0} | {1'b0, bf_ff & mask};
      k_hi     = k_lo | tt;
      last_round = (round_ff == status.lg - LOG_W'(1));
      tw_waddr = (bitrev(tw_cnt_ff) >> (LOG_W'(MAX_LOG_SIZE) - status.lg)) + ADDR_W'(1);
      accept   = start && (state_ff == S_IDLE);
   end

   always_comb begin
      cmd          = '0;
      cmd.coef_addr = req.index;
      state_in     = state_ff;
      tw_cnt_in    = tw_cnt_ff;
      slot_in      = slot_ff;
      round_in     = round_ff;
      bf_in        = bf_ff;
      rsp_valid_in = 1'b0;
      rsp_rej_in   = 1'b0;
      rsp_rd_in    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.func)
                  FUNC_WRITE: begin
                     cmd.coef_we   = !status.value_ge_q;
                     cmd.coef_wsel = WSEL_REQ;
                     rsp_valid_in  = 1'b1;
                     rsp_rej_in    = status.value_ge_q;
                  end
                  FUNC_READ: begin
                     cmd.coef_re  = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_rd_in    = 1'b1;
                  end
                  FUNC_RUN: state_in = S_ROOT;
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_ROOT: begin
            cmd.mul_start = 1'b1;
            cmd.mul_asel  = ASEL_ONE;
            cmd.mul_bsel  = BSEL_INV_ROOT;
            state_in      = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (status.mul_done) begin
               cmd.ld_root = 1'b1;
               tw_cnt_in   = '0;
               state_in    = S_TW_WRITE;
            end
         end
         S_TW_WRITE: begin
            cmd.tw_we     = 1'b1;
            cmd.tw_addr   = tw_waddr;
            cmd.mul_start = 1'b1;
            cmd.mul_asel  = ASEL_POWER;
            cmd.mul_bsel  = BSEL_ROOT;
            state_in      = S_TW_WAIT;
         end
         S_TW_WAIT: begin
            if (status.mul_done) begin
               cmd.ld_power = 1'b1;
               if (tw_cnt_ff == n_m2) begin
                  round_in = '0;
                  bf_in    = '0;
                  slot_in  = ADDR_W'(1);
                  state_in = S_RD_U;
               end else begin
                  tw_cnt_in = tw_cnt_ff + ADDR_W'(1);
                  state_in  = S_TW_WRITE;
               end
            end
         end
         S_RD_U: begin
            cmd.coef_re   = 1'b1;
            cmd.coef_addr = k_lo;
            cmd.tw_re     = 1'b1;
            cmd.tw_addr   = slot_ff;
            state_in      = S_CHK_U;
         end
         S_CHK_U: begin
            if (status.rdata_ge_q) begin
               cmd.mul_start = 1'b1;
               cmd.mul_asel  = ASEL_ONE;
               cmd.mul_bsel  = BSEL_RDATA;
               state_in      = S_RED_U;
            end else begin
               cmd.ld_u = 1'b1;
               state_in = S_RD_V;
            end
         end
         S_RED_U: begin
            if (status.mul_done) begin
               cmd.ld_u        = 1'b1;
               cmd.ld_from_mul = 1'b1;
               state_in        = S_RD_V;
            end
         end
         S_RD_V: begin
            cmd.coef_re   = 1'b1;
            cmd.coef_addr = k_hi;
            state_in      = S_CHK_V;
         end
         S_CHK_V: begin
            if (status.rdata_ge_q) begin
               cmd.mul_start = 1'b1;
               cmd.mul_asel  = ASEL_ONE;
               cmd.mul_bsel  = BSEL_RDATA;
               state_in      = S_RED_V;
            end else begin
               cmd.ld_v = 1'b1;
               state_in = S_BF_A;
            end
         end
         S_RED_V: begin
            if (status.mul_done) begin
               cmd.ld_v        = 1'b1;
               cmd.ld_from_mul = 1'b1;
               state_in        = S_BF_A;
            end
         end
         S_BF_A: begin
            cmd.mul_start = 1'b1;
            if (last_round) begin
               cmd.mul_asel = ASEL_SUM;
               cmd.mul_bsel = BSEL_INV_LEN;
               state_in     = S_MUL_A;
            end else begin
               cmd.coef_we   = 1'b1;
               cmd.coef_addr = k_lo;
               cmd.coef_wsel = WSEL_SUM;
               cmd.mul_asel  = ASEL_DIFF;
               cmd.mul_bsel  = BSEL_TWIDDLE;
               state_in      = S_MUL_B;
            end
         end
         S_MUL_A: begin
            if (status.mul_done) begin
               cmd.coef_we   = 1'b1;
               cmd.coef_addr = k_lo;
               cmd.coef_wsel = WSEL_MUL;
               cmd.mul_start = 1'b1;
               cmd.mul_asel  = ASEL_DIFF;
               cmd.mul_bsel  = BSEL_LAST;
               state_in      = S_MUL_B;
            end
         end
         S_MUL_B: begin
            if (status.mul_done) begin
               cmd.coef_we   = 1'b1;
               cmd.coef_addr = k_hi;
               cmd.coef_wsel = WSEL_MUL;
               if ((bf_ff & mask) == mask) begin
                  slot_in = slot_ff + ADDR_W'(1);
               end
               if (bf_ff == half_m1) begin
                  bf_in = '0;
                  if (last_round) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     round_in = round_ff + LOG_W'(1);
                     state_in = S_RD_U;
                  end
               end else begin
                  bf_in    = bf_ff + BF_W'(1);
                  state_in = S_RD_U;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_rej_ff   <= 1'b0;
         rsp_rd_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_rej_ff   <= rsp_rej_in;
         rsp_rd_ff    <= rsp_rd_in;
      end
      tw_cnt_ff <= tw_cnt_in;
      slot_ff   <= slot_in;
      round_ff  <= round_in;
      bf_ff     <= bf_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rejected = rsp_rej_ff;
   assign rsp_read     = rsp_rd_ff;

   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func != FUNC_RUN) |=> rsp_valid_ff)
      else $error("non-run item got no result");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy)
      else $error("multiplier started while busy");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      cmd.coef_we |-> !cmd.coef_re)
      else $error("coefficient memory read and write in one cycle");

   a_run_silent: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !rsp_valid_ff || state_ff == S_IDLE)
      else $error("result during a run");

endmodule

FILE: rtl/negacyclic_inverse_ntt.sv
// Top level of the negacyclic inverse NTT block.
// Write, read and no-op items are taken one per cycle while busy is low; each
// result strobes on rsp_valid in the cycle after the item and must be taken
// then. A run item holds busy high while it derives the root, builds the
// twiddle table and then runs the butterflies of the first log_n-1 rounds and
// of the final scaled round, plus one reduction for each operand read back at
// or above q; all of this runs on the 30-step serial modular multiplier, which
// every product and every operand reduction goes through, one at a time.
module negacyclic_inverse_ntt
   import intt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  coeff_type   csr_data
);

   cmd_type    cmd;
   status_type status;
   coeff_type  coef_rdata;
   logic       rsp_read, rsp_rejected;

   intt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req        (req_data),
      .cmd        (cmd),
      .status     (status),
      .coef_rdata (coef_rdata)
   );

   intt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_data),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_rejected (rsp_rejected),
      .rsp_read     (rsp_read)
   );

   assign csr_ready           = 1'b1;
   assign rsp_data.read_value = rsp_read ? coef_rdata : '0;
   assign rsp_data.rejected   = rsp_rejected;

endmodule

FILE: bench/tb.sv
// Testbench for negacyclic_inverse_ntt: directed table, then random config phases.
`timescale 1ns / 1ps

module tb;
   import intt_pkg::*;

   localparam int DEPTH = 1 << MAX_LOG_SIZE;
   localparam longint unsigned CMASK = (64'd1 << COEFF_WIDTH) - 1;

   typedef struct {
      func_type  func;
      addr_type  index;
      coeff_type value;
      bit        typed;
      coeff_type exp_value;
      bit        exp_rej;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_MODULUS;
   coeff_type   csr_data = '0;

   longint unsigned coef_mem [DEPTH];
   longint unsigned twiddle_mem [DEPTH];
   bit              known [DEPTH];
   longint unsigned cfg_q, cfg_root, cfg_inv_len, cfg_last;
   int unsigned     cfg_lg;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      items = 0;
   bit      idling = 0;
   row_type directed [$];

   negacyclic_inverse_ntt u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #200_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic longint unsigned eff_q();
      return (cfg_q < 3) ? 3 : cfg_q;
   endfunction

   function automatic int unsigned eff_lg();
      return (cfg_lg < 2) ? 2 : ((cfg_lg > MAX_LOG_SIZE) ? MAX_LOG_SIZE : cfg_lg);
   endfunction

   function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                              longint unsigned q);
      return ((a % q) * (b % q)) % q;
   endfunction

   function automatic int unsigned rev_bits(int unsigned x, int unsigned nb);
      int unsigned r;
      r = 0;
      for (int b = 0; b < nb; b++) begin
         r = (r << 1) | ((x >> b) & 1);
      end
      return r;
   endfunction

   function automatic void transform();
      longint unsigned q, root, pw, s, u, v;
      int unsigned lg, n, half, tt, h, slot, kstart;
      bit all_known;
      q = eff_q();
      lg = eff_lg();
      n = 1 << lg;
      half = n >> 1;
      root = cfg_root % q;
      pw = root;
      twiddle_mem[0] = 1;
      for (int unsigned i = 1; i < n; i++) begin
         twiddle_mem[(rev_bits(i - 1, lg) + 1) & (DEPTH - 1)] = pw;
         pw = mulmod(pw, root, q);
      end
      tt = 1;
      h = half;
      slot = 1;
      for (int unsigned rnd = 0; rnd + 1 < lg; rnd++) begin
         kstart = 0;
         for (int unsigned j = 0; j < h; j++) begin
            s = twiddle_mem[slot & (DEPTH - 1)];
            slot++;
            for (int unsigned k = kstart; k < kstart + tt; k++) begin
               u = coef_mem[k] % q;
               v = coef_mem[k + tt] % q;
               coef_mem[k] = (u + v) % q;
               coef_mem[k + tt] = mulmod((u + q - v) % q, s, q);
            end
            kstart += 2 * tt;
         end
         tt <<= 1;
         h >>= 1;
      end
      for (int unsigned i = 0; i < half; i++) begin
         u = coef_mem[i] % q;
         v = coef_mem[i + half] % q;
         coef_mem[i] = mulmod((u + v) % q, cfg_inv_len, q);
         coef_mem[i + half] = mulmod((u + q - v) % q, cfg_last, q);
      end
      all_known = 1;
      for (int unsigned i = 0; i < n; i++) all_known &= known[i];
      for (int unsigned i = 0; i < n; i++) known[i] = all_known;
   endfunction

   function automatic rsp_type coeff_step(req_type r);
      rsp_type o;
      o = '0;
      case (r.func)
         FUNC_WRITE: begin
            if (longint'(r.value) >= eff_q()) begin
               o.rejected = 1;
            end else begin
               coef_mem[r.index] = 64'(r.value);
               known[r.index] = 1;
            end
         end
         FUNC_READ: o.read_value = coeff_type'(coef_mem[r.index] & CMASK);
         FUNC_RUN: transform();
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_data.read_value !== exp_r.read_value ||
                rsp_data.rejected !== exp_r.rejected) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: read_value exp %0d got %0d, rejected exp %0d got %0d",
                           exp_r.read_value, rsp_data.read_value,
                           exp_r.rejected, rsp_data.rejected);
            end
         end
      end
   end

   // called at a falling edge; returns at a falling edge with start still high
   task automatic issue(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type p;
      if (idling && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = coeff_step(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
      items++;
      @(negedge clock);
   endtask

   task automatic send(input func_type f, input addr_type idx, input coeff_type val);
      req_type r;
      r.func = f;
      r.index = idx;
      r.value = val;
      issue(r, 0, '0);
   endtask

   task automatic settle();
      start <= 0;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input coeff_type val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODULUS:        cfg_q = 64'(val);
         CSR_LOG_SIZE:       cfg_lg = 32'(val[3:0]);
         CSR_INVERSE_ROOT:   cfg_root = 64'(val);
         CSR_INVERSE_LENGTH: cfg_inv_len = 64'(val);
         CSR_LAST_SCALE:     cfg_last = 64'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 15)) @(negedge clock);
   endtask

   function automatic coeff_type rand_coeff();
      coeff_type c;
      c = coeff_type'($urandom());
      return c;
   endfunction

   function automatic coeff_type write_value();
      if ($urandom_range(0, 9) == 0) return rand_coeff();
      return coeff_type'($urandom_range(0, int'(eff_q() - 1)));
   endfunction

   function automatic row_type mk(func_type f, addr_type i, coeff_type v, bit t,
                                  coeff_type ev, bit er);
      row_type w;
      w.func = f; w.index = i; w.value = v; w.typed = t; w.exp_value = ev; w.exp_rej = er;
      return w;
   endfunction

   initial begin
      req_type r;
      rsp_type tr;
      int unsigned n, lgc, idx, cnt;
      cfg_q = RST_MODULUS;
      cfg_lg = RST_LOG_SIZE;
      cfg_root = RST_INVERSE_ROOT;
      cfg_inv_len = RST_INVERSE_LENGTH;
      cfg_last = RST_LAST_SCALE;
      for (int i = 0; i < DEPTH; i++) begin
         coef_mem[i] = 0;
         twiddle_mem[i] = 0;
         known[i] = 0;
      end

      directed.push_back(mk(FUNC_WRITE, 0, 0, 1, 0, 0));
      directed.push_back(mk(FUNC_WRITE, 4095, RST_MODULUS - 30'd1, 1, 0, 0));
      directed.push_back(mk(FUNC_WRITE, 5, 30'h3FFFFFFF, 1, 0, 1));
      directed.push_back(mk(FUNC_WRITE, 6, RST_MODULUS, 1, 0, 1));
      directed.push_back(mk(FUNC_READ, 4095, 0, 1, RST_MODULUS - 30'd1, 0));
      directed.push_back(mk(FUNC_READ, 0, 0, 1, 0, 0));
      directed.push_back(mk(FUNC_NOP, 4095, 30'h3FFFFFFF, 1, 0, 0));
      directed.push_back(mk(FUNC_WRITE, 1, 30'h2AAAAAAA, 1, 0, 0));
      directed.push_back(mk(FUNC_WRITE, 2, 30'h15555555, 1, 0, 0));
      directed.push_back(mk(FUNC_READ, 1, 0, 1, 30'h2AAAAAAA, 0));
      directed.push_back(mk(FUNC_READ, 2, 0, 1, 30'h15555555, 0));
      directed.push_back(mk(FUNC_RUN, 0, 0, 1, 0, 0));
      directed.push_back(mk(FUNC_WRITE, 3, 7, 1, 0, 0));
      directed.push_back(mk(FUNC_READ, 3, 0, 1, 7, 0));
      directed.push_back(mk(FUNC_READ, 0, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (directed[i]) begin
         r.func = directed[i].func;
         r.index = directed[i].index;
         r.value = directed[i].value;
         tr.read_value = directed[i].exp_value;
         tr.rejected = directed[i].exp_rej;
         // a read of an entry that a run left undefined is skipped
         if (r.func != FUNC_READ || known[r.index]) issue(r, directed[i].typed, tr);
      end
      settle();
      csr_write(CSR_LOG_SIZE, coeff_type'(15));

      idling = 1;
      while (items < 1200) begin
         if (items > 1000) idling = 0;
         settle();
         case ($urandom_range(0, 9))
            0: csr_write(CSR_MODULUS, coeff_type'($urandom_range(0, 3)));
            1: csr_write(CSR_MODULUS, 30'h3FFFFFFF);
            default: csr_write(CSR_MODULUS, coeff_type'($urandom_range(3, 30'h3FFFFFFF)));
         endcase
         case ($urandom_range(0, 9))
            0: lgc = $urandom_range(0, 2);
            1: lgc = $urandom_range(6, 8);
            default: lgc = $urandom_range(2, 5);
         endcase
         csr_write(CSR_LOG_SIZE, coeff_type'(lgc));
         csr_write(CSR_INVERSE_ROOT, $urandom_range(0, 3) == 0 ? rand_coeff()
                   : coeff_type'($urandom_range(0, int'(eff_q() - 1))));
         csr_write(CSR_INVERSE_LENGTH, $urandom_range(0, 3) == 0 ? rand_coeff()
                   : coeff_type'($urandom_range(0, int'(eff_q() - 1))));
         csr_write(CSR_LAST_SCALE, $urandom_range(0, 3) == 0 ? rand_coeff()
                   : coeff_type'($urandom_range(0, int'(eff_q() - 1))));
         n = 1 << eff_lg();
         for (int unsigned k = 0; k < n; k++) send(FUNC_WRITE, addr_type'(k), write_value());
         for (int unsigned k = 0; k < n; k++)
            if (!known[k]) send(FUNC_WRITE, addr_type'(k),
                                coeff_type'($urandom_range(0, int'(eff_q() - 1))));
         cnt = $urandom_range(1, 2);
         for (int c = 0; c < cnt; c++) begin
            send(FUNC_RUN, addr_type'($urandom()), rand_coeff());
            for (int unsigned k = 0; k < n; k++)
               if (known[k]) send(FUNC_READ, addr_type'(k), rand_coeff());
         end
         repeat ($urandom_range(2, 8)) begin
            idx = $urandom_range(0, DEPTH - 1);
            case ($urandom_range(0, 3))
               0: send(FUNC_WRITE, addr_type'(idx), rand_coeff());
               1: send(FUNC_WRITE, addr_type'(idx), write_value());
               2: if (known[idx]) send(FUNC_READ, addr_type'(idx), rand_coeff());
                  else send(FUNC_NOP, addr_type'(idx), rand_coeff());
               default: send(FUNC_NOP, addr_type'(idx), rand_coeff());
            endcase
         end
      end
      settle();
      repeat (50) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
